[rtl/core/assert_macros.svh]
// assertion macros shared by the checker files
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define ASSERT_SAME(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("rope assertion failed");

// condition holds in the following cycle
`define ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("rope assertion failed");

`endif

[rtl/core/rope_pkg.sv]
// rope_pkg: constants, types and the arctangent table of the rotary embedding block
// no dependencies
package rope_pkg;

    localparam int MAX_PAIRS    = 64;
    localparam int CORDIC_STEPS = 24;

    localparam int IDX_W   = 6;
    localparam int POS_W   = 20;
    localparam int FREQ_W  = 31;
    localparam int VAL_W   = 32;
    localparam int ADDR_W  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int STEP_W  = 5;
    localparam int GUARD   = 8;
    localparam int XW      = 44;
    localparam int ZW      = 34;
    localparam int KW      = 30;
    localparam int TPP_W   = 39;
    localparam int PH_W    = 40;
    localparam int GW      = 23;
    localparam int PW      = XW + GW;

    localparam logic       KIND_LOAD   = 1'b0;
    localparam logic       KIND_ROTATE = 1'b1;

    localparam logic [KW-1:0]        TURN_SCALE = KW'(683565276);
    localparam logic signed [GW-1:0] GAIN_Q22   = GW'(2546889);

    typedef logic signed [XW-1:0] cx_t;
    typedef logic signed [ZW-1:0] cz_t;

    typedef struct packed {
        cx_t x;
        cx_t y;
        cz_t z;
    } cordic_t;

    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [31:0] a;
        case (i)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            5'd24:   a = 32'h00000029;
            5'd25:   a = 32'h00000014;
            5'd26:   a = 32'h0000000A;
            5'd27:   a = 32'h00000005;
            5'd28:   a = 32'h00000003;
            5'd29:   a = 32'h00000001;
            5'd30:   a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

[rtl/core/rope_ifs.sv]
// rope_in_if and rope_out_if: valid/ready channels of the rotary embedding block
// depends on rope_pkg
interface rope_in_if import rope_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [IDX_W-1:0]        pair_index;
    logic [POS_W-1:0]        position;
    logic [FREQ_W-1:0]       freq_word;
    logic signed [VAL_W-1:0] x_even;
    logic signed [VAL_W-1:0] x_odd;

    modport source (output valid, kind, pair_index, position, freq_word, x_even, x_odd,
                    input ready);
    modport sink   (input valid, kind, pair_index, position, freq_word, x_even, x_odd,
                    output ready);
endinterface

interface rope_out_if import rope_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] y_even;
    logic signed [VAL_W-1:0] y_odd;
    logic                    saturated;

    modport source (output valid, y_even, y_odd, saturated, input ready);
    modport sink   (input valid, y_even, y_odd, saturated, output ready);
endinterface

[rtl/core/rope_phase.sv]
// rope_phase: frequency table, angle product and quadrant fold ahead of the cordic cells
// depends on rope_pkg
module rope_phase import rope_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    kind,
    input  logic [IDX_W-1:0]        pair_index,
    input  logic [POS_W-1:0]        position,
    input  logic [FREQ_W-1:0]       freq_word,
    input  logic signed [VAL_W-1:0] x_even,
    input  logic signed [VAL_W-1:0] x_odd,
    output logic                    out_valid,
    input  logic                    out_ready,
    output cordic_t                 out_data
);

    localparam cz_t Z_QUARTER = ZW'(64'sd1073741824);
    localparam cz_t Z_HALF    = ZW'(64'sd2147483648);

    logic [FREQ_W-1:0] freq_mem [MAX_PAIRS];

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic r0, r1, r2, r3, r4;

    logic [FREQ_W-1:0]       freq0_reg;
    logic [POS_W-1:0]        pos0_reg, pos1_reg, pos2_reg;
    logic signed [VAL_W-1:0] xa0_reg, xa1_reg, xa2_reg, xa3_reg;
    logic signed [VAL_W-1:0] xb0_reg, xb1_reg, xb2_reg, xb3_reg;
    logic [KW+15:0]          plo1_reg;
    logic [KW+14:0]          phi1_reg;
    logic [TPP_W-1:0]        tpp2_reg;
    logic [PH_W-1:0]         ph3_reg;
    cordic_t                 c4_reg;

    logic              idx_ok;
    logic [ADDR_W-1:0] addr;
    logic              in_fire;
    logic [61:0]       tpp_sum;
    logic [PH_W:0]     ph_rnd;
    cz_t               z_raw;
    logic              fold;
    cx_t               xa_ext, xb_ext;
    cordic_t           c4_next;

    assign r4 = !v4_reg || out_ready;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign r0 = !v0_reg || r1;
    assign in_ready = r0;
    assign in_fire  = in_valid && r0;

    assign idx_ok = (int'(pair_index) < MAX_PAIRS);
    assign addr   = ADDR_W'(pair_index);

    assign tpp_sum = {phi1_reg, 16'b0} + 62'(plo1_reg) + 62'(1 << 21);

    assign ph_rnd = {1'b0, ph3_reg} + (PH_W+1)'(128);
    assign z_raw  = ZW'($signed(ph_rnd[39:8]));
    assign fold   = (z_raw > Z_QUARTER) || (z_raw < -Z_QUARTER);
    assign xa_ext = XW'(xa3_reg);
    assign xb_ext = XW'(xb3_reg);

    always_comb
    begin
        c4_next.x = (fold ? -xa_ext : xa_ext) <<< GUARD;
        c4_next.y = (fold ? -xb_ext : xb_ext) <<< GUARD;
        if (!fold)
        begin
            c4_next.z = z_raw;
        end
        else if (z_raw > 0)
        begin
            c4_next.z = z_raw - Z_HALF;
        end
        else
        begin
            c4_next.z = z_raw + Z_HALF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r0) v0_reg <= in_valid && (kind == KIND_ROTATE);
            if (r1) v1_reg <= v0_reg;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (kind == KIND_LOAD) && idx_ok)
        begin
            freq_mem[addr] <= freq_word;
        end
        if (r0)
        begin
            freq0_reg <= idx_ok ? freq_mem[addr] : '0;
            pos0_reg  <= position;
            xa0_reg   <= x_even;
            xb0_reg   <= x_odd;
        end
        if (r1)
        begin
            plo1_reg <= freq0_reg[15:0] * TURN_SCALE;
            phi1_reg <= freq0_reg[FREQ_W-1:16] * TURN_SCALE;
            pos1_reg <= pos0_reg;
            xa1_reg  <= xa0_reg;
            xb1_reg  <= xb0_reg;
        end
        if (r2)
        begin
            tpp2_reg <= tpp_sum[60:22];
            pos2_reg <= pos1_reg;
            xa2_reg  <= xa1_reg;
            xb2_reg  <= xb1_reg;
        end
        if (r3)
        begin
            ph3_reg <= PH_W'(tpp2_reg * pos2_reg);
            xa3_reg <= xa2_reg;
            xb3_reg <= xb2_reg;
        end
        if (r4)
        begin
            c4_reg <= c4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = c4_reg;

endmodule

[rtl/core/rope_cell.sv]
// rope_cell: one rotation-mode cordic step with its own pipeline register
// depends on rope_pkg
module rope_cell import rope_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [STEP_W-1:0] step,
    input  logic              in_valid,
    output logic              in_ready,
    input  cordic_t           in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cordic_t           out_data
);

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;
    cx_t     dx, dy;
    cz_t     at;

    assign in_ready = !valid_reg || out_ready;
    assign dx = in_data.y >>> step;
    assign dy = in_data.x >>> step;
    assign at = ZW'(atan_turn(step));

    always_comb
    begin
        if (in_data.z >= 0)
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - at;
        end
        else
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/core/rope_gain.sv]
// rope_gain: cordic gain correction, rounding and saturation, holds the output register
// depends on rope_pkg
module rope_gain import rope_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  cordic_t                 in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [VAL_W-1:0] y_even,
    output logic signed [VAL_W-1:0] y_odd,
    output logic                    saturated
);

    localparam logic signed [PW-1:0] V_MAX = PW'(64'sd2147483647);
    localparam logic signed [PW-1:0] V_MIN = PW'(-64'sd2147483648);
    localparam logic signed [PW-1:0] RND   = PW'(64'sd536870912);

    logic                    vm_reg, vo_reg;
    logic                    rm, ro;
    logic signed [PW-1:0]    mx_reg, my_reg;
    logic signed [PW-1:0]    sx, sy;
    logic                    cx_hi, cx_lo, cy_hi, cy_lo;
    logic signed [VAL_W-1:0] ye_reg, yo_reg, ye_next, yo_next;
    logic                    sat_reg, sat_next;

    assign ro = !vo_reg || out_ready;
    assign rm = !vm_reg || ro;
    assign in_ready = rm;

    assign sx = (mx_reg + RND) >>> 30;
    assign sy = (my_reg + RND) >>> 30;
    assign cx_hi = sx > V_MAX;
    assign cx_lo = sx < V_MIN;
    assign cy_hi = sy > V_MAX;
    assign cy_lo = sy < V_MIN;

    always_comb
    begin
        ye_next = cx_hi ? VAL_W'(V_MAX) : (cx_lo ? VAL_W'(V_MIN) : sx[VAL_W-1:0]);
        yo_next = cy_hi ? VAL_W'(V_MAX) : (cy_lo ? VAL_W'(V_MIN) : sy[VAL_W-1:0]);
        sat_next = cx_hi || cx_lo || cy_hi || cy_lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rm) vm_reg <= in_valid;
            if (ro) vo_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rm)
        begin
            mx_reg <= in_data.x * GAIN_Q22;
            my_reg <= in_data.y * GAIN_Q22;
        end
        if (ro)
        begin
            ye_reg  <= ye_next;
            yo_reg  <= yo_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = vo_reg;
    assign y_even    = ye_reg;
    assign y_odd     = yo_reg;
    assign saturated = sat_reg;

endmodule

[rtl/core/rotary_position_embedding.sv]
// rotary_position_embedding: top level, phase front end, cordic cell row, gain stage
// depends on rope_pkg, rope_ifs, rope_phase, rope_cell, rope_gain
//
// item channel: kind 0 writes freq_word into the frequency entry of pair_index and
// gives no result; kind 1 rotates (x_even, x_odd) by position times that frequency
// and gives one transaction on the result channel: y_even, y_odd, saturated.
// a rotate must only read an entry that an earlier load has written; a load may be
// followed by a rotate of the same pair in the very next cycle.
// path: table read, angle product and fold stages, one cordic cell per step
// (CORDIC_STEPS, 24 here), then the gain and saturation stages.
// throughput: one transaction per cycle while results are taken; every stage and cell
// has its own valid bit and moves on whenever the stage after it is empty or moving.
// reset clears all valid bits; the frequency table keeps no reset value.
// when the receiver stalls, results pile up stage by stage; item ready falls only
// once every stage holds a rotate transaction.
module rotary_position_embedding import rope_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    rope_in_if.sink     item,
    rope_out_if.source  result
);

    logic    cv [CORDIC_STEPS+1];
    logic    cr [CORDIC_STEPS+1];
    cordic_t cd [CORDIC_STEPS+1];

    rope_phase u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (item.valid),
        .in_ready   (item.ready),
        .kind       (item.kind),
        .pair_index (item.pair_index),
        .position   (item.position),
        .freq_word  (item.freq_word),
        .x_even     (item.x_even),
        .x_odd      (item.x_odd),
        .out_valid  (cv[0]),
        .out_ready  (cr[0]),
        .out_data   (cd[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        rope_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (STEP_W'(g)),
            .in_valid  (cv[g]),
            .in_ready  (cr[g]),
            .in_data   (cd[g]),
            .out_valid (cv[g+1]),
            .out_ready (cr[g+1]),
            .out_data  (cd[g+1])
        );
    end

    rope_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cv[CORDIC_STEPS]),
        .in_ready  (cr[CORDIC_STEPS]),
        .in_data   (cd[CORDIC_STEPS]),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .y_even    (result.y_even),
        .y_odd     (result.y_odd),
        .saturated (result.saturated)
    );

endmodule

[rtl/core/rope_checker.sv]
// rope_checker: port-level assertions of the rotary embedding block and its bind
// depends on rope_pkg and assert_macros.svh
`include "assert_macros.svh"

module rope_checker import rope_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [VAL_W-1:0] y_even,
    input logic signed [VAL_W-1:0] y_odd,
    input logic                    saturated
);

    localparam logic signed [VAL_W-1:0] Y_MAX = VAL_W'(64'sd2147483647);
    localparam logic signed [VAL_W-1:0] Y_MIN = VAL_W'(-64'sd2147483648);

    logic in_seen;
    logic at_rail;
    assign in_seen = in_valid;
    assign at_rail = (y_even == Y_MAX) || (y_even == Y_MIN) ||
                     (y_odd == Y_MAX) || (y_odd == Y_MIN);

    // empty output stage means the whole row drains, so items are taken
    `ASSERT_SAME(a_idle_ready, !out_valid, in_ready)
    // a clipped transaction carries at least one rail value
    `ASSERT_SAME(a_sat_rail, out_valid && saturated, at_rail)
    // stalled result holds
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(y_even) && $stable(y_odd) && $stable(saturated))
    // taking an item never leaves a stalled output valid dropping
    `ASSERT_NEXT(a_ready_hold, in_seen && in_ready && out_valid && !out_ready, out_valid)

endmodule

bind rotary_position_embedding rope_checker u_rope_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .y_even    (result.y_even),
    .y_odd     (result.y_odd),
    .saturated (result.saturated)
);

[bench/rope_bench_ifs.sv]
`timescale 1ns / 1ps
// bench_idle_gen: random pattern source for sender bursts and receiver stalls
// no dependencies; the channel interfaces come from rtl/core/rope_ifs.sv
module bench_idle_gen (
    input  logic clk,
    input  logic rst_n,
    input  logic hold,
    output logic go
);
    int run_left;
    int mode;

    initial
    begin
        go = 1'b0;
        run_left = 0;
        mode = 0;
    end

    always @(negedge clk)
    begin
        if (!rst_n || hold)
        begin
            go <= 1'b0;
        end
        else
        begin
            if (run_left == 0)
            begin
                mode = $urandom_range(0, 3);
                run_left = $urandom_range(1, 40);
            end
            run_left = run_left - 1;
            case (mode)
                0: go <= 1'b1;
                1: go <= ($urandom_range(0, 3) != 0);
                2: go <= ($urandom_range(0, 1) != 0);
                default: go <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end
endmodule

[bench/rotary_position_embedding_test.sv]
`timescale 1ns / 1ps
// rotary_position_embedding_test: self-checking bench of the rope pair rotator
// depends on rope_pkg, rope_ifs, rotary_position_embedding and bench_idle_gen
module rotary_position_embedding_test;
    import rope_pkg::*;

    localparam int LATENCY = 31;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic                    kind;
        logic [IDX_W-1:0]        pair_index;
        logic [POS_W-1:0]        position;
        logic [FREQ_W-1:0]       freq_word;
        logic signed [VAL_W-1:0] x_even;
        logic signed [VAL_W-1:0] x_odd;
        bit                      typed;
        logic signed [VAL_W-1:0] want_even;
        logic signed [VAL_W-1:0] want_odd;
        logic                    want_sat;
    } row_t;

    typedef struct {
        logic signed [VAL_W-1:0] y_even;
        logic signed [VAL_W-1:0] y_odd;
        logic                    saturated;
    } rotated_t;

    logic clk;
    logic rst_n;
    logic send_go;
    logic take_go;
    logic long_hold;
    int   errors;
    longint cycles;

    logic [FREQ_W-1:0] inv_freq [MAX_PAIRS];
    bit                loaded [MAX_PAIRS];
    rotated_t          pending_rotations [$];
    row_t              directed [$];

    rope_in_if  item ();
    rope_out_if result ();

    rotary_position_embedding dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    bench_idle_gen send_pattern (.clk(clk), .rst_n(rst_n), .hold(1'b0), .go(send_go));
    bench_idle_gen take_pattern (.clk(clk), .rst_n(rst_n), .hold(long_hold), .go(take_go));

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint gain_clamp(longint v, ref logic sat);
        longint g;
        g = floor_sh(v * 2546889 + (longint'(1) << 29), 30);
        if (g > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (g < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return g;
    endfunction

    function automatic rotated_t rotate_pair(logic [IDX_W-1:0] idx, logic [POS_W-1:0] pos,
                                             logic signed [VAL_W-1:0] xe,
                                             logic signed [VAL_W-1:0] xo);
        logic [63:0] freq;
        logic [63:0] tpp;
        logic [63:0] ph40;
        logic [31:0] p32;
        longint x, y, z, nx, ny;
        logic sat;
        rotated_t r;
        freq = (idx < MAX_PAIRS) ? 64'(inv_freq[idx]) : 64'd0;
        tpp = (freq * 64'd683565276 + (64'd1 << 21)) >> 22;
        ph40 = (tpp * 64'(pos)) & ((64'd1 << 40) - 64'd1);
        p32 = 32'((ph40 + 64'd128) >> 8);
        z = longint'($signed(p32));
        x = longint'(xe);
        y = longint'(xo);
        sat = 1'b0;
        if (z > (longint'(1) << 30) || z < -(longint'(1) << 30))
        begin
            x = -x;
            y = -y;
            z = (z > 0) ? z - (longint'(1) << 31) : z + (longint'(1) << 31);
        end
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_sh(y, i);
                ny = y + floor_sh(x, i);
                z = z - longint'(atan_turn(5'(i)));
            end
            else
            begin
                nx = x + floor_sh(y, i);
                ny = y - floor_sh(x, i);
                z = z + longint'(atan_turn(5'(i)));
            end
            x = nx;
            y = ny;
        end
        r.y_even = 32'(gain_clamp(x, sat));
        r.y_odd = 32'(gain_clamp(y, sat));
        r.saturated = sat;
        return r;
    endfunction

    task automatic add_row(logic k, int idx, int pos, logic [FREQ_W-1:0] fw,
                           logic signed [VAL_W-1:0] xe, logic signed [VAL_W-1:0] xo,
                           bit typed = 0, logic signed [VAL_W-1:0] we = 0,
                           logic signed [VAL_W-1:0] wo = 0, logic ws = 0);
        row_t r;
        r.kind = k;
        r.pair_index = IDX_W'(idx);
        r.position = POS_W'(pos);
        r.freq_word = fw;
        r.x_even = xe;
        r.x_odd = xo;
        r.typed = typed;
        r.want_even = we;
        r.want_odd = wo;
        r.want_sat = ws;
        directed = {directed, r};
    endtask

    // hand one item to the block; loads update the model, rotates book a result
    task automatic send(row_t r);
        rotated_t e;
        item.kind <= r.kind;
        item.pair_index <= r.pair_index;
        item.position <= r.position;
        item.freq_word <= r.freq_word;
        item.x_even <= r.x_even;
        item.x_odd <= r.x_odd;
        while (!send_go)
        begin
            item.valid <= 1'b0;
            @(negedge clk);
        end
        item.valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!item.ready);
        if (r.kind == KIND_LOAD)
        begin
            inv_freq[r.pair_index] = r.freq_word;
            loaded[r.pair_index] = 1'b1;
        end
        else
        begin
            e = rotate_pair(r.pair_index, r.position, r.x_even, r.x_odd);
            if (r.typed)
            begin
                if (e.y_even !== r.want_even)
                begin
                    $error("directed y_even expected %0d predicted %0d", r.want_even,
                           e.y_even);
                    errors++;
                end
                if (e.y_odd !== r.want_odd)
                begin
                    $error("directed y_odd expected %0d predicted %0d", r.want_odd,
                           e.y_odd);
                    errors++;
                end
                if (e.saturated !== r.want_sat)
                begin
                    $error("directed saturated expected %0b predicted %0b", r.want_sat,
                           e.saturated);
                    errors++;
                end
                e.y_even = r.want_even;
                e.y_odd = r.want_odd;
                e.saturated = r.want_sat;
            end
            pending_rotations = {pending_rotations, e};
        end
        @(negedge clk);
    endtask

    function automatic logic signed [VAL_W-1:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(0, 131072)) - 32'd65536);
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic logic [FREQ_W-1:0] rand_freq();
        case ($urandom_range(0, 5))
            0: return 31'h40000000;
            1: return 31'h7FFFFFFF;
            2: return FREQ_W'($urandom_range(0, 65535));
            default: return FREQ_W'($urandom());
        endcase
    endfunction

    // result side: ready follows the stall pattern, every transaction checked
    always @(negedge clk)
    begin
        result.ready <= rst_n && take_go;
    end

    always @(posedge clk)
    begin
        rotated_t e;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_rotations.size() == 0)
            begin
                $error("unexpected transaction y_even=%0d y_odd=%0d", result.y_even,
                       result.y_odd);
                errors++;
            end
            else
            begin
                e = pending_rotations.pop_front();
                if (result.y_even !== e.y_even)
                begin
                    $error("y_even expected %0d actual %0d", e.y_even, result.y_even);
                    errors++;
                end
                if (result.y_odd !== e.y_odd)
                begin
                    $error("y_odd expected %0d actual %0d", e.y_odd, result.y_odd);
                    errors++;
                end
                if (result.saturated !== e.saturated)
                begin
                    $error("saturated expected %0b actual %0b", e.saturated,
                           result.saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** rotary_position_embedding: FAILED **");
            $finish;
        end
    end

    // long receiver hold-off so the pipeline fills and item ready drops
    initial
    begin
        long_hold = 1'b0;
        wait (rst_n);
        repeat (300) @(posedge clk);
        long_hold = 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
    end

    initial
    begin
        row_t r;
        int wait_cycles;
        errors = 0;
        cycles = 0;
        rst_n = 1'b0;
        item.valid = 1'b0;
        item.kind = KIND_LOAD;
        item.pair_index = '0;
        item.position = '0;
        item.freq_word = '0;
        item.x_even = '0;
        item.x_odd = '0;
        result.ready = 1'b0;
        foreach (loaded[i])
        begin
            loaded[i] = 1'b0;
            inv_freq[i] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero angle passes values through the gain; zero inputs give zero
        add_row(KIND_LOAD, 0, 0, 31'h0, 0, 0);
        add_row(KIND_ROTATE, 0, 0, 31'h0, 0, 0, 1, 0, 0, 1'b0);
        add_row(KIND_ROTATE, 0, 1048575, 31'h0, 32'sh7FFFFFFF, 32'sh80000000);
        add_row(KIND_LOAD, 63, 0, 31'h40000000, 0, 0);
        add_row(KIND_ROTATE, 63, 1, 31'h0, 32'sh00010000, 0);
        add_row(KIND_ROTATE, 63, 1048575, 31'h0, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        add_row(KIND_ROTATE, 63, 3, 31'h0, 32'sh80000000, 32'sh80000000);
        add_row(KIND_LOAD, 5, 0, 31'h7FFFFFFF, 0, 0);
        add_row(KIND_ROTATE, 5, 1048575, 31'h0, 32'sh7FFFFFFF, 32'sh80000000);
        add_row(KIND_ROTATE, 5, 12345, 31'h0, -32'sh00010000, 32'sh00020000);
        add_row(KIND_LOAD, 9, 0, 31'h00000001, 0, 0);
        add_row(KIND_ROTATE, 9, 1048575, 31'h0, 32'sh12345678, -32'sh12345678);
        add_row(KIND_LOAD, 9, 1048575, 31'h2AAAAAAA, 32'sh7FFFFFFF, 32'sh80000000);
        add_row(KIND_ROTATE, 9, 2, 31'h0, 32'sh40000000, 32'sh40000000);
        add_row(KIND_ROTATE, 9, 7, 31'h55555555, 32'sh80000000, 32'sh7FFFFFFF);
        foreach (directed[i])
            send(directed[i]);

        for (int n = 0; n < 1150; n++)
        begin
            r.typed = 1'b0;
            r.position = POS_W'($urandom());
            if ($urandom_range(0, 3) == 0)
                r.position = POS_W'($urandom_range(0, 4096));
            r.freq_word = rand_freq();
            r.x_even = rand_val();
            r.x_odd = rand_val();
            r.pair_index = IDX_W'($urandom_range(0, MAX_PAIRS - 1));
            r.kind = ($urandom_range(0, 4) == 0) ? KIND_LOAD : KIND_ROTATE;
            if (r.kind == KIND_ROTATE && !loaded[r.pair_index])
                r.kind = KIND_LOAD;
            send(r);
        end
        item.valid <= 1'b0;

        wait_cycles = 0;
        while (pending_rotations.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && pending_rotations.size() == 0)
            $display("** rotary_position_embedding: PASSED **");
        else
            $display("** rotary_position_embedding: FAILED **");
        $finish;
    end
endmodule
